// File: design/integer_alu_with_floor_div_unit_assert.svh
// Assertion macros used by the checker file ialu_chk.sv.
`ifndef INTEGER_ALU_WITH_FLOOR_DIV_UNIT_ASSERT_SVH
`define INTEGER_ALU_WITH_FLOOR_DIV_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define IALU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ialu assertion failed");

// Next-cycle implication, off during reset.
`define IALU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ialu assertion failed");

// Implication that is also checked through reset.
`define IALU_ASSERT_ALW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("ialu assertion failed");

`endif

// File: design/ialu_pkg.sv
`timescale 1ns / 1ps
package ialu_pkg;

    localparam int IALU_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int OP_W       = 5;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_NEG  = 5'd0;
    localparam opcode_t OP_INC  = 5'd1;
    localparam opcode_t OP_DEC  = 5'd2;
    localparam opcode_t OP_ADD  = 5'd3;
    localparam opcode_t OP_SUB  = 5'd4;
    localparam opcode_t OP_MUL  = 5'd5;
    localparam opcode_t OP_TDIV = 5'd6;
    localparam opcode_t OP_REM  = 5'd7;
    localparam opcode_t OP_MOD  = 5'd8;
    localparam opcode_t OP_FDIV = 5'd9;
    localparam opcode_t OP_AND  = 5'd10;
    localparam opcode_t OP_OR   = 5'd11;
    localparam opcode_t OP_XOR  = 5'd12;
    localparam opcode_t OP_NOT  = 5'd13;
    localparam opcode_t OP_SHL  = 5'd14;
    localparam opcode_t OP_SHR  = 5'd15;
    localparam opcode_t OP_LSB  = 5'd16;
    localparam opcode_t OP_MSB  = 5'd17;
    localparam opcode_t OP_POP  = 5'd18;
    localparam opcode_t OP_ABS  = 5'd19;
    localparam opcode_t OP_SIGN = 5'd20;
    localparam opcode_t OP_GCD  = 5'd21;
    localparam opcode_t OP_POW  = 5'd22;
    localparam opcode_t OP_EQ   = 5'd23;
    localparam opcode_t OP_NE   = 5'd24;
    localparam opcode_t OP_LT   = 5'd25;
    localparam opcode_t OP_LE   = 5'd26;
    localparam opcode_t OP_GT   = 5'd27;
    localparam opcode_t OP_GE   = 5'd28;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_MUL,
        ST_DIV,
        ST_DSIGN,
        ST_SCAN,
        ST_GCHK,
        ST_GDIV,
        ST_GUPD,
        ST_PCHK,
        ST_PMR,
        ST_PMS,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MSRC_OP,
        MSRC_POW_RES,
        MSRC_POW_SQR
    } mul_src_t;

    typedef enum logic {
        DSRC_OP,
        DSRC_GCD
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_src_t mul_src;
        logic     mul_step;
        logic     div_start;
        div_src_t div_src;
        logic     div_step;
        logic     div_sign;
        logic     scan_start;
        logic     scan_step;
        logic     gcd_init;
        logic     gcd_update;
        logic     pow_init;
        logic     pow_take_res;
        logic     pow_take_sq;
        logic     finish;
    } ialu_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    b_zero;
        logic    b_neg;
        logic    mul_done;
        logic    cnt_last;
        logic    gcd_y_zero;
        logic    exp_zero;
        logic    exp_lsb;
    } ialu_sts_t;

endpackage

// File: design/ialu_ctrl.sv
`timescale 1ns / 1ps
module ialu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ialu_pkg::ialu_sts_t  sts,
    output ialu_pkg::ialu_cmd_t  cmd
);
    import ialu_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DISP;
            ST_DISP: begin
                unique case (sts.op) inside
                    OP_MUL: state_next = ST_MUL;
                    OP_TDIV, OP_REM, OP_MOD, OP_FDIV:
                        state_next = sts.b_zero ? ST_FIN : ST_DIV;
                    OP_LSB, OP_MSB, OP_POP: state_next = ST_SCAN;
                    OP_GCD: state_next = ST_GCHK;
                    OP_POW: state_next = sts.b_neg ? ST_FIN : ST_PCHK;
                    default: state_next = ST_FIN;
                endcase
            end
            ST_MUL:   if (sts.mul_done) state_next = ST_FIN;
            ST_DIV:   if (sts.cnt_last) state_next = ST_DSIGN;
            ST_DSIGN: state_next = ST_FIN;
            ST_SCAN:  if (sts.cnt_last) state_next = ST_FIN;
            ST_GCHK:  state_next = sts.gcd_y_zero ? ST_FIN : ST_GDIV;
            ST_GDIV:  if (sts.cnt_last) state_next = ST_GUPD;
            ST_GUPD:  state_next = ST_GCHK;
            ST_PCHK: begin
                if (sts.exp_zero) state_next = ST_FIN;
                else state_next = sts.exp_lsb ? ST_PMR : ST_PMS;
            end
            ST_PMR:   if (sts.mul_done) state_next = ST_PMS;
            ST_PMS:   if (sts.mul_done) state_next = ST_PCHK;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd         = '0;
        cmd.mul_src = MSRC_OP;
        cmd.div_src = DSRC_OP;
        unique case (state_reg)
            ST_IDLE: cmd.load = s_valid;
            ST_DISP: begin
                unique case (sts.op) inside
                    OP_MUL: cmd.mul_start = 1'b1;
                    OP_TDIV, OP_REM, OP_MOD, OP_FDIV: cmd.div_start = !sts.b_zero;
                    OP_LSB, OP_MSB, OP_POP: cmd.scan_start = 1'b1;
                    OP_GCD: cmd.gcd_init = 1'b1;
                    OP_POW: cmd.pow_init = !sts.b_neg;
                    default: ;
                endcase
            end
            ST_MUL:   cmd.mul_step = !sts.mul_done;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_DSIGN: cmd.div_sign = 1'b1;
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_GCHK: begin
                cmd.div_start = !sts.gcd_y_zero;
                cmd.div_src   = DSRC_GCD;
            end
            ST_GDIV:  cmd.div_step = 1'b1;
            ST_GUPD:  cmd.gcd_update = 1'b1;
            ST_PCHK: begin
                cmd.mul_start = !sts.exp_zero;
                cmd.mul_src   = sts.exp_lsb ? MSRC_POW_RES : MSRC_POW_SQR;
            end
            ST_PMR: begin
                if (sts.mul_done) begin
                    cmd.pow_take_res = 1'b1;
                    cmd.mul_start    = 1'b1;
                    cmd.mul_src      = MSRC_POW_SQR;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_PMS: begin
                if (sts.mul_done) cmd.pow_take_sq = 1'b1;
                else cmd.mul_step = 1'b1;
            end
            ST_FIN:   cmd.finish = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.finish) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

endmodule

// File: design/ialu_dp.sv
`timescale 1ns / 1ps
module ialu_dp #(
    parameter int WIDTH = ialu_pkg::IALU_WIDTH
) (
    input  logic                          aclk,
    input  ialu_pkg::ialu_cmd_t           cmd,
    input  logic [ialu_pkg::OP_W-1:0]     s_req_type,
    input  logic [ialu_pkg::FIELD_W-1:0]  s_operand_a,
    input  logic [ialu_pkg::FIELD_W-1:0]  s_operand_b,
    output ialu_pkg::ialu_sts_t           sts,
    output logic [ialu_pkg::FIELD_W-1:0]  m_result_value,
    output logic                          m_error_code
);
    import ialu_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam int PW = $clog2(WIDTH + 1);

    opcode_t          op_reg;
    logic [WIDTH-1:0] a_reg, b_reg;
    logic [WIDTH-1:0] m_acc_reg, m_cand_reg, m_plier_reg;
    logic [WIDTH-1:0] d_quo_reg, d_rem_reg, d_dvs_reg;
    logic [WIDTH-1:0] g_x_reg, g_y_reg;
    logic [WIDTH-1:0] p_res_reg, p_base_reg, p_exp_reg;
    logic [WIDTH-1:0] sc_bits_reg;
    logic [PW-1:0]    sc_pop_reg;
    logic [CW-1:0]    sc_lsb_reg, sc_msb_reg, cnt_reg;
    logic             sc_found_reg;
    logic [FIELD_W-1:0] res_reg;
    logic             err_reg;

    logic             a_neg, b_neg;
    logic [WIDTH-1:0] a_mag, b_mag;
    logic [WIDTH:0]   trial, diff;
    logic             ge;
    logic [WIDTH-1:0] q_s, r_s;
    logic             fl_adj;
    logic [CW-1:0]    sh;
    logic             lt, gt;
    logic [WIDTH-1:0] ones, pow_neg_res;
    logic [WIDTH-1:0] res_next;
    logic             err_next;

    assign a_neg = a_reg[WIDTH-1];
    assign b_neg = b_reg[WIDTH-1];
    assign a_mag = a_neg ? -a_reg : a_reg;
    assign b_mag = b_neg ? -b_reg : b_reg;
    assign ones  = '1;

    // restoring divider step
    assign trial = {d_rem_reg, d_quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, d_dvs_reg};
    assign ge    = !diff[WIDTH];

    assign q_s = (a_neg ^ b_neg) ? -d_quo_reg : d_quo_reg;
    assign r_s = a_neg ? -d_rem_reg : d_rem_reg;
    assign fl_adj = (d_rem_reg != '0) && (d_rem_reg[WIDTH-1] != b_neg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_req_type;
            a_reg  <= s_operand_a[WIDTH-1:0];
            b_reg  <= s_operand_b[WIDTH-1:0];
        end

        if (cmd.mul_start) begin
            m_acc_reg <= '0;
            case (cmd.mul_src)
                MSRC_POW_RES: begin
                    m_cand_reg  <= p_res_reg;
                    m_plier_reg <= p_base_reg;
                end
                MSRC_POW_SQR: begin
                    m_cand_reg  <= p_base_reg;
                    m_plier_reg <= p_base_reg;
                end
                default: begin
                    m_cand_reg  <= a_reg;
                    m_plier_reg <= b_reg;
                end
            endcase
        end else if (cmd.mul_step) begin
            if (m_plier_reg[0]) m_acc_reg <= m_acc_reg + m_cand_reg;
            m_cand_reg  <= m_cand_reg << 1;
            m_plier_reg <= m_plier_reg >> 1;
        end

        if (cmd.div_start) begin
            d_rem_reg <= '0;
            if (cmd.div_src == DSRC_GCD) begin
                d_quo_reg <= g_x_reg;
                d_dvs_reg <= g_y_reg;
            end else begin
                d_quo_reg <= a_mag;
                d_dvs_reg <= b_mag;
            end
        end else if (cmd.div_step) begin
            d_rem_reg <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            d_quo_reg <= {d_quo_reg[WIDTH-2:0], ge};
        end else if (cmd.div_sign) begin
            d_quo_reg <= q_s;
            d_rem_reg <= r_s;
        end

        if (cmd.gcd_init) begin
            g_x_reg <= a_mag;
            g_y_reg <= b_mag;
        end else if (cmd.gcd_update) begin
            g_x_reg <= g_y_reg;
            g_y_reg <= d_rem_reg;
        end

        if (cmd.pow_init) begin
            p_res_reg  <= WIDTH'(1);
            p_base_reg <= a_reg;
            p_exp_reg  <= b_reg;
        end else begin
            if (cmd.pow_take_res) p_res_reg <= m_acc_reg;
            if (cmd.pow_take_sq) begin
                p_base_reg <= m_acc_reg;
                p_exp_reg  <= p_exp_reg >> 1;
            end
        end

        if (cmd.scan_start) begin
            sc_bits_reg  <= a_reg;
            sc_pop_reg   <= '0;
            sc_lsb_reg   <= '0;
            sc_msb_reg   <= '0;
            sc_found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            sc_bits_reg <= sc_bits_reg >> 1;
            if (sc_bits_reg[0]) begin
                sc_pop_reg   <= sc_pop_reg + PW'(1);
                sc_msb_reg   <= cnt_reg;
                sc_found_reg <= 1'b1;
                if (!sc_found_reg) sc_lsb_reg <= cnt_reg;
            end
        end

        if (cmd.div_start || cmd.scan_start) cnt_reg <= '0;
        else if (cmd.div_step || cmd.scan_step) cnt_reg <= cnt_reg + CW'(1);

        if (cmd.finish) begin
            res_reg <= FIELD_W'($signed(res_next));
            err_reg <= err_next;
        end
    end

    // saturated shift amount
    always_comb begin
        if (b_neg) sh = '0;
        else if (b_reg > WIDTH'(WIDTH - 1)) sh = CW'(WIDTH - 1);
        else sh = b_reg[CW-1:0];
    end

    assign lt = $signed(a_reg) < $signed(b_reg);
    assign gt = $signed(b_reg) < $signed(a_reg);

    // negative exponent
    always_comb begin
        if (a_reg == WIDTH'(1)) pow_neg_res = WIDTH'(1);
        else if (a_reg == ones) pow_neg_res = b_reg[0] ? ones : WIDTH'(1);
        else pow_neg_res = '0;
    end

    always_comb begin
        res_next = '0;
        err_next = 1'b0;
        unique case (op_reg) inside
            OP_NEG:  res_next = -a_reg;
            OP_INC:  res_next = a_reg + WIDTH'(1);
            OP_DEC:  res_next = a_reg - WIDTH'(1);
            OP_ADD:  res_next = a_reg + b_reg;
            OP_SUB:  res_next = a_reg - b_reg;
            OP_MUL:  res_next = m_acc_reg;
            OP_TDIV, OP_REM, OP_MOD, OP_FDIV: begin
                if (b_reg == '0) begin
                    err_next = 1'b1;
                end else begin
                    case (op_reg)
                        OP_TDIV: res_next = d_quo_reg;
                        OP_REM:  res_next = d_rem_reg;
                        OP_MOD:  res_next = fl_adj ? d_rem_reg + b_reg : d_rem_reg;
                        default: res_next = fl_adj ? d_quo_reg - WIDTH'(1) : d_quo_reg;
                    endcase
                end
            end
            OP_AND:  res_next = a_reg & b_reg;
            OP_OR:   res_next = a_reg | b_reg;
            OP_XOR:  res_next = a_reg ^ b_reg;
            OP_NOT:  res_next = ~a_reg;
            OP_SHL:  res_next = a_reg << sh;
            OP_SHR:  res_next = WIDTH'($signed(a_reg) >>> sh);
            OP_LSB:  res_next = sc_found_reg ? WIDTH'(sc_lsb_reg) : ones;
            OP_MSB:  res_next = sc_found_reg ? WIDTH'(sc_msb_reg) : ones;
            OP_POP:  res_next = WIDTH'(sc_pop_reg);
            OP_ABS:  res_next = a_mag;
            OP_SIGN: res_next = a_neg ? ones : WIDTH'(a_reg != '0);
            OP_GCD:  res_next = g_x_reg;
            OP_POW: begin
                if (b_neg) begin
                    res_next = pow_neg_res;
                    err_next = (a_reg == '0);
                end else begin
                    res_next = p_res_reg;
                end
            end
            OP_EQ:   res_next = WIDTH'(a_reg == b_reg);
            OP_NE:   res_next = WIDTH'(a_reg != b_reg);
            OP_LT:   res_next = WIDTH'(lt);
            OP_LE:   res_next = WIDTH'(!gt);
            OP_GT:   res_next = WIDTH'(gt);
            OP_GE:   res_next = WIDTH'(!lt);
            default: res_next = '0;
        endcase
    end

    always_comb begin
        sts            = '0;
        sts.op         = op_reg;
        sts.b_zero     = (b_reg == '0);
        sts.b_neg      = b_neg;
        sts.mul_done   = (m_plier_reg == '0);
        sts.cnt_last   = (cnt_reg == CW'(WIDTH - 1));
        sts.gcd_y_zero = (g_y_reg == '0);
        sts.exp_zero   = (p_exp_reg == '0);
        sts.exp_lsb    = p_exp_reg[0];
    end

    assign m_result_value = res_reg;
    assign m_error_code   = err_reg;

endmodule

// File: design/integer_alu_with_floor_div_unit.sv
// Simple ops need no iteration; mul uses a shift-add multiplier that ends early once the multiplier is zero.
// Div/rem/mod/floor-div: restoring divider, one quotient bit per cycle; a zero divisor skips the divider.
// lsb/msb/popcount: serial bit scan. gcd: one divider pass per Euclid step.
// pow: square-and-multiply per exponent bit (shared shift-add multiplier); a negative exponent skips it.
// One request in flight; the next is accepted once the controller is back in idle after the result is registered.
// Reset (aresetn low, synchronous): controller returns to idle and m_valid clears.
`timescale 1ns / 1ps
module integer_alu_with_floor_div_unit #(
    parameter int WIDTH = ialu_pkg::IALU_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ialu_pkg::OP_W-1:0]     s_req_type,
    input  logic [ialu_pkg::FIELD_W-1:0]  s_operand_a,
    input  logic [ialu_pkg::FIELD_W-1:0]  s_operand_b,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ialu_pkg::FIELD_W-1:0]  m_result_value,
    output logic                          m_error_code
);
    import ialu_pkg::*;

    // controller drives commands, datapath reports status back
    ialu_cmd_t cmd;
    ialu_sts_t sts;

    // Controller: request intake, op dispatch, iteration sequencing
    // (multiplier, divider, bit scan, gcd and pow loops), output register valid.
    ialu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: operand registers, shift-add multiplier, restoring divider,
    // scan unit, gcd/pow working registers and the result register.
    ialu_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .s_req_type     (s_req_type),
        .s_operand_a    (s_operand_a),
        .s_operand_b    (s_operand_b),
        .sts            (sts),
        .m_result_value (m_result_value),
        .m_error_code   (m_error_code)
    );

endmodule

// File: design/ialu_chk.sv
`timescale 1ns / 1ps
`include "integer_alu_with_floor_div_unit_assert.svh"
module ialu_chk #(
    parameter int WIDTH = ialu_pkg::IALU_WIDTH
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ialu_pkg::FIELD_W-1:0]  m_result_value,
    input logic                          m_error_code
);
    import ialu_pkg::*;

    // result held while stalled
    `IALU_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_error_code))
    // an error result always carries a zero value
    `IALU_ASSERT_IMP(a_err_zero, m_valid && m_error_code, m_result_value == '0)
    // busy right after taking a request
    `IALU_ASSERT_NXT(a_busy, s_valid && s_ready, !s_ready)
    // reset empties the output register
    `IALU_ASSERT_ALW(a_rst_empty, $past(!aresetn), !m_valid)

endmodule

bind integer_alu_with_floor_div_unit ialu_chk #(
    .WIDTH (WIDTH)
) u_ialu_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_error_code   (m_error_code)
);

// File: test/integer_alu_with_floor_div_unit_checker.sv
`timescale 1ns / 1ps
module integer_alu_with_floor_div_unit_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ialu_pkg::OP_W-1:0]    s_req_type,
    input  logic [ialu_pkg::FIELD_W-1:0] s_operand_a,
    input  logic [ialu_pkg::FIELD_W-1:0] s_operand_b,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [ialu_pkg::FIELD_W-1:0] m_result_value,
    input  logic                         m_error_code,
    output int                           mismatches,
    output int                           outstanding
);
    import ialu_pkg::*;

    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [63:0] value;
        logic        err;
    } alu_result_t;

    alu_result_t result_q[$];

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic alu_result_t alu_compute(opcode_t op, logic [63:0] a, logic [63:0] b);
        alu_result_t o;
        logic [63:0] ua, ub, q, r, t, s, acc;
        o = '0;
        case (op)
            OP_NEG: o.value = 64'd0 - a;
            OP_INC: o.value = a + 64'd1;
            OP_DEC: o.value = a - 64'd1;
            OP_ADD: o.value = a + b;
            OP_SUB: o.value = a - b;
            OP_MUL: o.value = a * b;
            OP_TDIV, OP_REM, OP_MOD, OP_FDIV: begin
                if (b == 64'd0) begin
                    o.err = 1'b1;
                end else begin
                    ua = magnitude(a);
                    ub = magnitude(b);
                    q = ua / ub;
                    r = ua % ub;
                    if (a[63] != b[63]) q = 64'd0 - q;
                    if (a[63]) r = 64'd0 - r;
                    // floored forms: pull remainder to the divisor's sign
                    if ((op == OP_MOD || op == OP_FDIV) && r != 64'd0 && r[63] != b[63]) begin
                        r = r + b;
                        q = q - 64'd1;
                    end
                    o.value = (op == OP_TDIV || op == OP_FDIV) ? q : r;
                end
            end
            OP_AND: o.value = a & b;
            OP_OR:  o.value = a | b;
            OP_XOR: o.value = a ^ b;
            OP_NOT: o.value = ~a;
            OP_SHL, OP_SHR: begin
                if (b[63]) s = 64'd0;
                else if (b > 64'd63) s = 64'd63;
                else s = b;
                if (op == OP_SHL) o.value = a << s[5:0];
                else o.value = $signed(a) >>> s[5:0];
            end
            OP_LSB, OP_MSB: begin
                o.value = ALL_ONES;
                for (int i = 63; i >= 0; i--) begin
                    if (op == OP_LSB && a[i]) o.value = 64'(i);
                end
                for (int i = 0; i < 64; i++) begin
                    if (op == OP_MSB && a[i]) o.value = 64'(i);
                end
            end
            OP_POP: for (int i = 0; i < 64; i++) o.value += 64'(a[i]);
            OP_ABS: o.value = magnitude(a);
            OP_SIGN: o.value = a[63] ? ALL_ONES : (a != 64'd0 ? 64'd1 : 64'd0);
            OP_GCD: begin
                q = magnitude(a);
                r = magnitude(b);
                while (r != 64'd0) begin
                    t = q % r;
                    q = r;
                    r = t;
                end
                o.value = q;
            end
            OP_POW: begin
                if (b[63]) begin
                    if (a == 64'd1) o.value = 64'd1;
                    else if (a == ALL_ONES) o.value = b[0] ? ALL_ONES : 64'd1;
                    else if (a == 64'd0) o.err = 1'b1;
                end else begin
                    acc = 64'd1;
                    t = a;
                    s = b;
                    while (s != 64'd0) begin
                        if (s[0]) acc = acc * t;
                        t = t * t;
                        s = s >> 1;
                    end
                    o.value = acc;
                end
            end
            OP_EQ: o.value = 64'(a == b);
            OP_NE: o.value = 64'(a != b);
            OP_LT: o.value = 64'($signed(a) <  $signed(b));
            OP_LE: o.value = 64'($signed(a) <= $signed(b));
            OP_GT: o.value = 64'($signed(a) >  $signed(b));
            OP_GE: o.value = 64'($signed(a) >= $signed(b));
            default: o = '0;
        endcase
        return o;
    endfunction

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                result_q.push_back(alu_compute(s_req_type, s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result: value %h err %b", m_result_value, m_error_code);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (m_result_value !== want.value) begin
                        $error("result_value: expected %h actual %h", want.value, m_result_value);
                        mismatches++;
                    end
                    if (m_error_code !== want.err) begin
                        $error("error_code: expected %b actual %b", want.err, m_error_code);
                        mismatches++;
                    end
                end
            end
            outstanding <= result_q.size();
        end
    end

endmodule

// File: test/integer_alu_with_floor_div_unit_tb.sv
`timescale 1ns / 1ps
module integer_alu_with_floor_div_unit_tb;
    import ialu_pkg::*;

    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG_ONE = '1;
    localparam int RANDOM_REQS = 1650;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_req_type;
    logic [FIELD_W-1:0] s_operand_a;
    logic [FIELD_W-1:0] s_operand_b;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_result_value;
    logic               m_error_code;

    int   mismatches;
    int   outstanding;
    logic req_taken;     // handshake seen at the last rising edge
    int   burst_left;

    integer_alu_with_floor_div_unit DUT (.*);

    integer_alu_with_floor_div_unit_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) req_taken <= s_valid && s_ready;

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Operand mix: corner values, small numbers, full random patterns.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return NEG_ONE;
            3: return MIN_VAL;
            4: return MAX_VAL;
            5, 6: return 64'($signed($urandom_range(0, 200)) - 100);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Exponents stay mostly small; a long one costs many multiplies.
    function automatic logic [63:0] pick_exponent();
        case ($urandom_range(0, 19))
            0, 1, 2: return {1'b1, 31'($urandom()), $urandom()};
            3: return {$urandom(), $urandom()};
            4: return NEG_ONE;
            default: return 64'($urandom_range(0, 40));
        endcase
    endfunction

    // Present one request at the falling edge and hold it until taken.
    // Sender may idle between bursts; within a burst valid stays high.
    task automatic send_request(opcode_t op, logic [63:0] a, logic [63:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid     = 1'b1;
        s_req_type  = op;
        s_operand_a = a;
        s_operand_b = b;
        do @(negedge aclk); while (!req_taken);
    endtask

    // Receiver: a long hold-off early so the block backs up, then
    // randomly chosen stretches of random stalls or full readiness.
    initial begin
        int stretch;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        m_ready = 1'b1;
        repeat (20) @(negedge aclk);
        m_ready = 1'b0;
        repeat (600) @(negedge aclk);
        forever begin
            stretch = $urandom_range(10, 200);
            if ($urandom_range(0, 2) == 0) begin
                m_ready = 1'b1;
                repeat (stretch) @(negedge aclk);
            end else begin
                repeat (stretch) begin
                    m_ready = $urandom_range(0, 2) != 0;
                    @(negedge aclk);
                end
            end
        end
    end

    initial begin
        opcode_t     op;
        logic [63:0] a;
        logic [63:0] b;
        int          wait_cycles;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req_type  = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        burst_left  = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed corners
        send_request(OP_TDIV, 64'd7, 64'd0);          // zero divisor
        send_request(OP_MOD, NEG_ONE, 64'd0);
        send_request(OP_TDIV, MIN_VAL, NEG_ONE);      // most negative quotient wraps
        send_request(OP_REM, MIN_VAL, NEG_ONE);
        send_request(OP_MOD, 64'd7, -64'sd3);         // floored vs truncating
        send_request(OP_FDIV, -64'sd7, 64'd2);
        send_request(OP_SHL, 64'd1, NEG_ONE);         // negative shift acts as 0
        send_request(OP_SHR, MIN_VAL, 64'd100);       // oversized shift saturates
        send_request(OP_LSB, 64'd0, 64'd0);           // no set bit
        send_request(OP_MSB, 64'd0, 64'd0);
        send_request(OP_MSB, NEG_ONE, 64'd0);
        send_request(OP_POP, NEG_ONE, 64'd0);
        send_request(OP_ABS, MIN_VAL, 64'd0);         // wraps
        send_request(OP_GCD, 64'd0, 64'd0);
        send_request(OP_GCD, MIN_VAL, 64'd0);         // gcd of 2^63 wraps
        send_request(OP_POW, 64'd0, 64'd0);           // 0^0 is 1
        send_request(OP_POW, 64'd0, NEG_ONE);         // error
        send_request(OP_POW, NEG_ONE, -64'sd3);
        send_request(OP_POW, NEG_ONE, -64'sd4);
        send_request(OP_POW, 64'd1, MIN_VAL);
        send_request(OP_POW, 64'd2, NEG_ONE);
        send_request(OP_MUL, MAX_VAL, MAX_VAL);
        send_request(OP_ADD, MAX_VAL, 64'd1);
        send_request(OP_LT, MIN_VAL, MAX_VAL);
        send_request(opcode_t'(5'd31), NEG_ONE, NEG_ONE); // unused opcode

        // Random requests over every opcode, unused ones included
        repeat (RANDOM_REQS) begin
            op = opcode_t'($urandom_range(0, 31));
            a  = pick_operand();
            b  = (op == OP_POW) ? pick_exponent() : pick_operand();
            if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 1))
                b = 64'($urandom_range(0, 70));
            send_request(op, a, b);
        end
        s_valid = 1'b0;

        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 200000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (200) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
